@@ hdl/cea_pkg.sv @@
// Shared types, codes and constants for the conditional execute stage.
`timescale 1ns / 1ps
`default_nettype none
package cea_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int MEM_ROWS = MEM_BYTES / 4;
   localparam int ROW_BITS = $clog2(MEM_ROWS);
   localparam int ADDR_BITS = $clog2(MEM_BYTES);
   localparam int ITEM_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;

   localparam logic [2:0] FAULT_NONE = 3'd0;
   localparam logic [2:0] FAULT_TYPE = 3'd1;
   localparam logic [2:0] FAULT_COND = 3'd2;
   localparam logic [2:0] FAULT_OPCODE = 3'd3;
   localparam logic [2:0] FAULT_ADDR = 3'd4;

   localparam logic [3:0] PC_INDEX = 4'd15;

   typedef enum logic [2:0] {
      KIND_BAD_COND,
      KIND_MUL,
      KIND_DP,
      KIND_BAD_OP,
      KIND_LS,
      KIND_BRANCH,
      KIND_BAD_TYPE
   } kind_type;

   typedef struct packed {
      logic [31:0] instr;
      kind_type    kind;
   } item_type;

   typedef struct packed {
      logic        cond_passed;
      logic [2:0]  fault_code;
      logic        branch_taken;
      logic [31:0] branch_target;
      logic        dest_written;
      logic [3:0]  dest_index;
      logic [31:0] dest_value;
      logic [3:0]  flags_nzcv;
   } rsp_type;

   typedef struct packed {
      logic                 wr;
      logic                 rd;
      logic [ADDR_BITS-1:0] addr;
      logic [31:0]          wdata;
   } mem_req_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_LOAD
   } st_type;

endpackage
`default_nettype wire

@@ hdl/cea_mem.sv @@
// Byte-addressed data memory in four byte banks with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module cea_mem (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cea_pkg::mem_req_type req,
   output logic                 ready,
   output logic [31:0]          rdata
);

   logic                         clearing_ff;
   logic [cea_pkg::ROW_BITS-1:0] clr_row_ff;
   logic [1:0]                   off;
   logic [1:0]                   off_ff;
   logic [cea_pkg::ROW_BITS-1:0] row;
   logic [7:0]                   rbyte [4];

   assign off = req.addr[1:0];
   assign row = req.addr[cea_pkg::ADDR_BITS-1:2];
   assign ready = !clearing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_row_ff <= '0;
      end else if (clearing_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == cea_pkg::ROW_BITS'(cea_pkg::MEM_ROWS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd) begin
         off_ff <= off;
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [7:0]                   mem_ff [cea_pkg::MEM_ROWS];
      logic [7:0]                   rd_ff;
      logic [1:0]                   idx;
      logic [cea_pkg::ROW_BITS-1:0] row_k;

      assign idx = 2'(k) - off;
      assign row_k = row + cea_pkg::ROW_BITS'(2'(k) < off);
      assign rbyte[k] = rd_ff;

      always_ff @(posedge clock) begin
         if (clearing_ff) begin
            mem_ff[clr_row_ff] <= 8'h00;
         end else if (req.wr) begin
            mem_ff[row_k] <= req.wdata[8*idx +: 8];
         end
         if (req.rd) begin
            rd_ff <= mem_ff[row_k];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rdata[8*i +: 8] = rbyte[2'(i) + off_ff];
      end
   end

endmodule
`default_nettype wire

@@ hdl/cea_front.sv @@
// Front part: accepts instruction words, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none
module cea_front (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [31:0]  instr_word,
   input  wire logic         accept_en,
   output logic              item_valid,
   output cea_pkg::item_type item,
   input  wire logic         item_pop
);

   cea_pkg::item_type q_ff [cea_pkg::ITEM_DEPTH];
   logic [1:0]        cnt_ff;
   logic              rptr_ff;
   logic              wptr_ff;
   logic              do_push;
   cea_pkg::kind_type kind;

   always_comb begin
      kind = cea_pkg::KIND_BAD_TYPE;
      case (instr_word[31:28]) inside
         cea_pkg::COND_EQ, cea_pkg::COND_NE, cea_pkg::COND_GE, cea_pkg::COND_LT,
         cea_pkg::COND_GT, cea_pkg::COND_LE, cea_pkg::COND_AL: begin
            unique case (instr_word[27:26])
               2'b00: begin
                  if (instr_word[27:22] == 6'd0 && instr_word[7:4] == 4'b1001) begin
                     kind = cea_pkg::KIND_MUL;
                  end else begin
                     case (instr_word[24:21]) inside
                        cea_pkg::OP_AND, cea_pkg::OP_EOR, cea_pkg::OP_SUB, cea_pkg::OP_RSB,
                        cea_pkg::OP_ADD, cea_pkg::OP_TST, cea_pkg::OP_TEQ, cea_pkg::OP_CMP,
                        cea_pkg::OP_ORR, cea_pkg::OP_MOV: kind = cea_pkg::KIND_DP;
                        default: kind = cea_pkg::KIND_BAD_OP;
                     endcase
                  end
               end
               2'b01: kind = cea_pkg::KIND_LS;
               2'b10: kind = instr_word[25] ? cea_pkg::KIND_BRANCH : cea_pkg::KIND_BAD_TYPE;
               default: kind = cea_pkg::KIND_BAD_TYPE;
            endcase
         end
         default: kind = cea_pkg::KIND_BAD_COND;
      endcase
   end

   assign full = (cnt_ff == 2'(cea_pkg::ITEM_DEPTH)) || !accept_en;
   assign do_push = push && !full;
   assign item_valid = cnt_ff != 2'd0;
   assign item = q_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rptr_ff <= 1'b0;
         wptr_ff <= 1'b0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (item_pop) begin
            rptr_ff <= !rptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(item_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= '{instr: instr_word, kind: kind};
      end
   end

endmodule
`default_nettype wire

@@ hdl/cea_back.sv @@
// Back part: register state, condition test, execution, memory access, result queue.
`timescale 1ns / 1ps
`default_nettype none
module cea_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire cea_pkg::item_type item,
   output logic              item_pop,
   output logic              accept_en,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output cea_pkg::rsp_type  rsp
);

   logic [31:0]          regs_ff [15];
   logic [31:0]          pc_ff;
   logic [3:0]           flags_ff;
   cea_pkg::st_type      st_ff;
   cea_pkg::st_type      st_in;
   cea_pkg::rsp_type     oq_ff [cea_pkg::RSP_DEPTH];
   logic [1:0]           ocnt_ff;
   logic                 ordp_ff;
   logic                 owrp_ff;
   logic                 ld_base_wr_ff;
   logic [3:0]           ld_base_idx_ff;
   logic [31:0]          ld_base_val_ff;
   logic [3:0]           ld_rd_ff;
   logic [31:0]          view [16];
   cea_pkg::mem_req_type mreq;
   logic                 mready;
   logic [31:0]          mrdata;
   logic                 fire;
   logic                 go_load;
   logic                 out_push;
   logic                 do_pop;
   cea_pkg::rsp_type     ex_rsp;
   cea_pkg::rsp_type     push_rsp;
   logic [3:0]           flags_in;
   logic [31:0]          pc_in;
   logic                 wr_en;
   logic [3:0]           wr_idx;
   logic [31:0]          wr_val;

   function automatic logic [32:0] barrel(logic [31:0] v, logic [1:0] ty, logic [7:0] amt,
                                          logic cin);
      logic [32:0] t;
      logic [32:0] res;
      logic [63:0] dbl;
      t = '0;
      dbl = '0;
      res = {cin, v};
      if (amt != 8'd0) begin
         case (ty)
            2'd0: begin
               t = {1'b0, v} << amt[5:0];
               res = (amt <= 8'd32) ? t : 33'd0;
            end
            2'd1: begin
               t = {v, 1'b0} >> amt[5:0];
               res = (amt <= 8'd32) ? {t[0], t[32:1]} : 33'd0;
            end
            2'd2: begin
               if (amt >= 8'd32) begin
                  res = {v[31], {32{v[31]}}};
               end else begin
                  t = 33'($signed({v, 1'b0}) >>> amt[4:0]);
                  res = {t[0], t[32:1]};
               end
            end
            default: begin
               if (amt[4:0] == 5'd0) begin
                  res = {v[31], v};
               end else begin
                  dbl = {v, v} >> amt[4:0];
                  res = {dbl[31], dbl[31:0]};
               end
            end
         endcase
      end
      return res;
   endfunction

   always_comb begin
      for (int i = 0; i < 15; i++) begin
         view[i] = regs_ff[i];
      end
      view[15] = pc_ff;
   end

   cea_mem u_mem (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .ready (mready),
      .rdata (mrdata)
   );

   always_comb begin
      logic [31:0] w;
      logic        n, z, c, v;
      logic        passed;
      logic [32:0] sh;
      logic [31:0] opa, opb, res, off, base, addr;
      logic [32:0] sum;
      logic        cout;
      logic [7:0]  amt;
      logic [63:0] prod;
      w = item.instr;
      n = flags_ff[3];
      z = flags_ff[2];
      c = flags_ff[1];
      v = flags_ff[0];
      sh = '0;
      opa = '0;
      opb = '0;
      res = '0;
      off = '0;
      base = '0;
      addr = '0;
      sum = '0;
      cout = c;
      amt = '0;
      prod = '0;
      ex_rsp = '0;
      flags_in = flags_ff;
      pc_in = pc_ff;
      wr_en = 1'b0;
      wr_idx = '0;
      wr_val = '0;
      go_load = 1'b0;
      mreq = '0;

      case (w[31:28])
         cea_pkg::COND_EQ: passed = z;
         cea_pkg::COND_NE: passed = !z;
         cea_pkg::COND_GE: passed = n == v;
         cea_pkg::COND_LT: passed = n != v;
         cea_pkg::COND_GT: passed = !z && n == v;
         cea_pkg::COND_LE: passed = z || n != v;
         default: passed = 1'b1;
      endcase

      if (w[25] && item.kind != cea_pkg::KIND_LS) begin
         sh = barrel({24'd0, w[7:0]}, 2'd3, {3'd0, w[11:8], 1'b0}, c);
      end else if (w[4]) begin
         sh = barrel(view[w[3:0]], w[6:5], view[w[11:8]][7:0], c);
      end else if (w[11:7] == 5'd0 && w[6:5] == 2'd0) begin
         sh = {c, view[w[3:0]]};
      end else if (w[11:7] == 5'd0 && w[6:5] == 2'd3) begin
         sh = {view[w[3:0]][0], c, view[w[3:0]][31:1]};
      end else begin
         amt = (w[11:7] == 5'd0) ? 8'd32 : {3'd0, w[11:7]};
         sh = barrel(view[w[3:0]], w[6:5], amt, c);
      end

      if (item.kind == cea_pkg::KIND_BAD_COND) begin
         ex_rsp.fault_code = cea_pkg::FAULT_COND;
      end else if (!passed) begin
         pc_in = pc_ff + 32'd4;
      end else begin
         ex_rsp.cond_passed = 1'b1;
         pc_in = pc_ff + 32'd4;
         unique case (item.kind)
            cea_pkg::KIND_MUL: begin
               prod = view[w[3:0]] * view[w[11:8]];
               res = prod[31:0] + (w[21] ? view[w[15:12]] : 32'd0);
               wr_en = w[19:16] != cea_pkg::PC_INDEX;
               wr_idx = w[19:16];
               wr_val = res;
               if (w[20]) begin
                  flags_in = {res[31], res == 32'd0, flags_ff[1:0]};
               end
            end
            cea_pkg::KIND_DP: begin
               opa = view[w[19:16]];
               opb = sh[31:0];
               cout = sh[32];
               unique case (w[24:21])
                  cea_pkg::OP_AND, cea_pkg::OP_TST: res = opa & opb;
                  cea_pkg::OP_EOR, cea_pkg::OP_TEQ: res = opa ^ opb;
                  cea_pkg::OP_SUB, cea_pkg::OP_CMP: begin
                     res = opa - opb;
                     cout = opa >= opb;
                  end
                  cea_pkg::OP_RSB: begin
                     res = opb - opa;
                     cout = opb >= opa;
                  end
                  cea_pkg::OP_ADD: begin
                     sum = {1'b0, opa} + {1'b0, opb};
                     res = sum[31:0];
                     cout = sum[32];
                  end
                  cea_pkg::OP_ORR: res = opa | opb;
                  default: res = opb;
               endcase
               if (w[24:21] != cea_pkg::OP_TST && w[24:21] != cea_pkg::OP_TEQ &&
                   w[24:21] != cea_pkg::OP_CMP) begin
                  wr_en = w[15:12] != cea_pkg::PC_INDEX;
                  wr_idx = w[15:12];
                  wr_val = res;
               end
               if (w[20]) begin
                  flags_in = {res[31], res == 32'd0, cout, flags_ff[0]};
               end
            end
            cea_pkg::KIND_BAD_OP: begin
               ex_rsp.cond_passed = 1'b0;
               ex_rsp.fault_code = cea_pkg::FAULT_OPCODE;
               pc_in = pc_ff;
            end
            cea_pkg::KIND_LS: begin
               off = w[25] ? sh[31:0] : {20'd0, w[11:0]};
               if (!w[23]) begin
                  off = 32'd0 - off;
               end
               base = view[w[19:16]];
               addr = w[24] ? base + off : base;
               if (addr > 32'(cea_pkg::MEM_BYTES - 4)) begin
                  ex_rsp.cond_passed = 1'b0;
                  ex_rsp.fault_code = cea_pkg::FAULT_ADDR;
                  pc_in = pc_ff;
               end else begin
                  if (!w[24]) begin
                     wr_en = w[19:16] != cea_pkg::PC_INDEX;
                     wr_idx = w[19:16];
                     wr_val = base + off;
                  end
                  mreq.addr = addr[cea_pkg::ADDR_BITS-1:0];
                  mreq.wdata = view[w[15:12]];
                  if (w[20]) begin
                     mreq.rd = 1'b1;
                     go_load = 1'b1;
                  end else begin
                     mreq.wr = 1'b1;
                  end
               end
            end
            cea_pkg::KIND_BRANCH: begin
               off = {{6{w[23]}}, w[23:0], 2'b00};
               ex_rsp.branch_taken = 1'b1;
               ex_rsp.branch_target = pc_ff + off;
               pc_in = pc_ff + off + 32'd8;
            end
            default: begin
               ex_rsp.cond_passed = 1'b0;
               ex_rsp.fault_code = cea_pkg::FAULT_TYPE;
               pc_in = pc_ff;
            end
         endcase
      end
      ex_rsp.dest_written = wr_en;
      ex_rsp.dest_index = wr_en ? wr_idx : 4'd0;
      ex_rsp.dest_value = wr_en ? wr_val : 32'd0;
      ex_rsp.flags_nzcv = flags_in;
      if (!fire) begin
         mreq = '0;
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         cea_pkg::ST_CLEAR: st_in = mready ? cea_pkg::ST_RUN : cea_pkg::ST_CLEAR;
         cea_pkg::ST_RUN: st_in = (fire && go_load) ? cea_pkg::ST_LOAD : cea_pkg::ST_RUN;
         default: st_in = cea_pkg::ST_RUN;
      endcase
   end

   always_comb begin
      accept_en = st_ff != cea_pkg::ST_CLEAR;
      fire = (st_ff == cea_pkg::ST_RUN) && item_valid && (ocnt_ff != 2'(cea_pkg::RSP_DEPTH));
      item_pop = fire;
      out_push = (fire && !go_load) || (st_ff == cea_pkg::ST_LOAD);
   end

   always_comb begin
      push_rsp = ex_rsp;
      if (st_ff == cea_pkg::ST_LOAD) begin
         push_rsp = '0;
         push_rsp.cond_passed = 1'b1;
         push_rsp.flags_nzcv = flags_ff;
         if (ld_rd_ff != cea_pkg::PC_INDEX) begin
            push_rsp.dest_written = 1'b1;
            push_rsp.dest_index = ld_rd_ff;
            push_rsp.dest_value = mrdata;
         end else if (ld_base_wr_ff) begin
            push_rsp.dest_written = 1'b1;
            push_rsp.dest_index = ld_base_idx_ff;
            push_rsp.dest_value = ld_base_val_ff;
         end
      end
   end

   assign do_pop = rsp_pop && !rsp_empty;
   assign rsp_empty = ocnt_ff == 2'd0;
   assign rsp = oq_ff[ordp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= cea_pkg::ST_CLEAR;
         pc_ff <= 32'd8;
         flags_ff <= 4'd0;
         for (int i = 0; i < 15; i++) begin
            regs_ff[i] <= 32'd0;
         end
         ocnt_ff <= '0;
         ordp_ff <= 1'b0;
         owrp_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (fire) begin
            pc_ff <= pc_in;
            flags_ff <= flags_in;
            if (wr_en) begin
               regs_ff[wr_idx] <= wr_val;
            end
         end
         if (st_ff == cea_pkg::ST_LOAD && ld_rd_ff != cea_pkg::PC_INDEX) begin
            regs_ff[ld_rd_ff] <= mrdata;
         end
         if (out_push) begin
            owrp_ff <= !owrp_ff;
         end
         if (do_pop) begin
            ordp_ff <= !ordp_ff;
         end
         ocnt_ff <= ocnt_ff + 2'(out_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         oq_ff[owrp_ff] <= push_rsp;
      end
      if (fire && go_load) begin
         ld_rd_ff <= item.instr[15:12];
         ld_base_wr_ff <= wr_en;
         ld_base_idx_ff <= wr_idx;
         ld_base_val_ff <= wr_val;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cond_execute_alu_load_store.sv @@
// Top level of the conditional execute stage: front queue and back execution unit.
//
//   channel   direction  handshake              word
//   req_      in         push / full            req_instr_word
//   rsp_      out        empty / pop            rsp_cond_passed .. rsp_flags_nzcv
//
// An instruction is executed in the ST_RUN state; a load also passes through ST_LOAD, since the
// byte-bank memory read is registered before the register write-back.
// After reset a clearing pass zeroes all 16384 memory rows, one row of four bytes a
// cycle; full stays high meanwhile.
// Two-word queues on both sides let input and output stall independently.
`timescale 1ns / 1ps
`default_nettype none
module cond_execute_alu_load_store (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_instr_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_cond_passed,
   output logic [2:0]       rsp_fault_code,
   output logic             rsp_branch_taken,
   output logic [31:0]      rsp_branch_target,
   output logic             rsp_dest_written,
   output logic [3:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic [3:0]       rsp_flags_nzcv
);

   cea_pkg::item_type item;
   logic              item_valid;
   logic              item_pop;
   logic              accept_en;
   cea_pkg::rsp_type  rsp;

   cea_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .instr_word (req_instr_word),
      .accept_en  (accept_en),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   cea_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .accept_en  (accept_en),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_cond_passed = rsp.cond_passed;
   assign rsp_fault_code = rsp.fault_code;
   assign rsp_branch_taken = rsp.branch_taken;
   assign rsp_branch_target = rsp.branch_target;
   assign rsp_dest_written = rsp.dest_written;
   assign rsp_dest_index = rsp.dest_index;
   assign rsp_dest_value = rsp.dest_value;
   assign rsp_flags_nzcv = rsp.flags_nzcv;

endmodule
`default_nettype wire
